// ===== src/mkdr_pkg.sv =====
// Shared constants, types and codes for the matrix key debounce and repeat unit.
package mkdr_pkg;

    localparam int unsigned LINE_W  = 4;
    localparam int unsigned CFG_W   = 8;
    localparam int unsigned KEY_W   = 5;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned POS_W   = 2;

    localparam logic [CFG_W-1:0]  PRESS_SATURATE = 8'd200;
    localparam logic [CFG_W-1:0]  DEBOUNCE_RESET = 8'd5;
    localparam logic [CFG_W-1:0]  REPEAT_RESET   = 8'd55;
    localparam logic [KEY_W-1:0]  KEY_BASE       = 5'd4;
    localparam logic [LINE_W-1:0] LINES_IDLE     = 4'hF;

    typedef enum logic [0:0] {
        CFG_DEBOUNCE_COUNT = 1'b0,
        CFG_REPEAT_PERIOD  = 1'b1
    } cfg_index_t;

    typedef enum logic [KIND_W-1:0] {
        EVT_PRESS   = 2'd0,
        EVT_REPEAT  = 2'd1,
        EVT_RELEASE = 2'd2
    } event_kind_t;

    typedef struct packed {
        logic [LINE_W-1:0] rows;
        logic [LINE_W-1:0] cols;
    } scan_item_t;

    typedef struct packed {
        logic              emit;
        event_kind_t       kind;
        logic [KEY_W-1:0]  key;
    } key_event_t;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
    } key_code_t;

endpackage

// ===== src/mkdr_decode.sv =====
// Key code decoder: one low row and one low column give a key number.
module mkdr_decode
    import mkdr_pkg::*;
(
    input  logic [LINE_W-1:0] rows,
    input  logic [LINE_W-1:0] cols,
    output key_code_t         code
);

    logic             row_ok;
    logic             col_ok;
    logic [POS_W-1:0] row_pos;
    logic [POS_W-1:0] col_pos;

    always_comb
    begin
        row_ok  = 1'b1;
        row_pos = '0;
        case (rows)
            4'h7:    row_pos = 2'd0;
            4'hB:    row_pos = 2'd1;
            4'hD:    row_pos = 2'd2;
            4'hE:    row_pos = 2'd3;
            default: row_ok  = 1'b0;
        endcase
    end

    always_comb
    begin
        col_ok  = 1'b1;
        col_pos = '0;
        case (cols)
            4'h7:    col_pos = 2'd0;
            4'hB:    col_pos = 2'd1;
            4'hD:    col_pos = 2'd2;
            4'hE:    col_pos = 2'd3;
            default: col_ok  = 1'b0;
        endcase
    end

    assign code.valid = row_ok & col_ok;
    assign code.key   = KEY_BASE + {1'b0, col_pos, row_pos};

endmodule

// ===== src/mkdr_core.sv =====
// Debounce, repeat and release state with its configuration registers.
module mkdr_core
    import mkdr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  cfg_index_t       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             fire,
    input  scan_item_t       item,
    output key_event_t       result
);

    logic [CFG_W-1:0] debounce_reg;
    logic [CFG_W-1:0] period_reg;
    logic [CFG_W-1:0] ticks_reg;
    logic [CFG_W-1:0] ticks_next;
    logic             pending_reg;
    logic             pending_next;
    logic [KEY_W-1:0] held_reg;
    logic [KEY_W-1:0] held_next;
    logic [CFG_W-1:0] countdown_reg;
    logic [CFG_W-1:0] countdown_next;

    logic [CFG_W-1:0] limit;
    logic             stepped;
    logic [CFG_W-1:0] ticks_inc;
    logic [CFG_W-1:0] countdown_dec;
    key_code_t        code;

    mkdr_decode u_decode
    (
        .rows (item.rows),
        .cols (item.cols),
        .code (code)
    );

    always_comb
    begin
        limit          = (debounce_reg == '0) ? CFG_W'(1) : debounce_reg;
        stepped        = ticks_reg < PRESS_SATURATE;
        ticks_inc      = stepped ? ticks_reg + CFG_W'(1) : ticks_reg;
        countdown_dec  = countdown_reg - CFG_W'(1);
        ticks_next     = ticks_reg;
        pending_next   = pending_reg;
        held_next      = held_reg;
        countdown_next = countdown_reg;
        result.emit    = 1'b0;
        result.kind    = EVT_PRESS;
        result.key     = held_reg;

        if (item.rows == LINES_IDLE)
        begin
            ticks_next = '0;
            if (pending_reg)
            begin
                pending_next = 1'b0;
                result.emit  = 1'b1;
                result.kind  = EVT_RELEASE;
            end
        end
        else
        begin
            ticks_next = ticks_inc;
            if (ticks_inc < limit)
            begin
                ticks_next = ticks_inc;
            end
            else if (ticks_inc == limit && stepped)
            begin
                if (!code.valid)
                begin
                    ticks_next     = '0;
                    pending_next   = 1'b0;
                    held_next      = '0;
                    countdown_next = '0;
                end
                else
                begin
                    pending_next   = 1'b1;
                    countdown_next = period_reg;
                    held_next      = code.key;
                    result.emit    = 1'b1;
                    result.kind    = EVT_PRESS;
                    result.key     = code.key;
                end
            end
            else if (countdown_reg != '0)
            begin
                countdown_next = countdown_dec;
                if (countdown_dec == '0)
                begin
                    countdown_next = period_reg;
                    if (period_reg != '0)
                    begin
                        result.emit = 1'b1;
                        result.kind = EVT_REPEAT;
                    end
                end
            end
            else
            begin
                countdown_next = period_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= DEBOUNCE_RESET;
            period_reg    <= REPEAT_RESET;
            ticks_reg     <= '0;
            pending_reg   <= 1'b0;
            held_reg      <= '0;
            countdown_reg <= REPEAT_RESET;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_DEBOUNCE_COUNT)
            begin
                debounce_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_REPEAT_PERIOD)
            begin
                period_reg <= cfg_data;
            end
            if (fire)
            begin
                ticks_reg     <= ticks_next;
                pending_reg   <= pending_next;
                held_reg      <= held_next;
                countdown_reg <= countdown_next;
            end
        end
    end

endmodule

// ===== src/matrix_key_debounce_repeat_unit.sv =====
// Top level of the 4x4 matrix keypad debounce, auto-repeat and release unit.
//
//   channel   handshake               payload
//   ------    ---------               -------
//   input     in_valid / in_ready     row_lines[3:0], column_lines[3:0]
//   output    out_valid / out_ready   event_kind[1:0], key_number[4:0]
//   config    cfg_we                  cfg_index, cfg_data[7:0]
//
// One transaction per cycle sustained while no result waits at the output;
// the input register captures a transaction at acceptance, then decode and
// state update load the result register once the output slot is free. At
// most one result per scan transaction.
// Reset clears the state and loads the default debounce and repeat values.
// A waiting result stalls the state update; the input register still takes
// one more transaction while the result waits.
module matrix_key_debounce_repeat_unit
    import mkdr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [LINE_W-1:0] row_lines,
    input  logic [LINE_W-1:0] column_lines,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [KIND_W-1:0] event_kind,
    output logic [KEY_W-1:0]  key_number
);

    logic        item_valid_reg;
    scan_item_t  item_reg;
    logic        fire;
    key_event_t  result;
    logic        out_valid_reg;
    event_kind_t kind_reg;
    logic [KEY_W-1:0] key_reg;

    assign fire     = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || fire;

    mkdr_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index_t'(cfg_index)),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (item_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
            if (fire && result.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.rows <= row_lines;
            item_reg.cols <= column_lines;
        end
        if (fire && result.emit)
        begin
            kind_reg <= result.kind;
            key_reg  <= result.key;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = kind_reg;
    assign key_number = key_reg;

endmodule
